// File: rtl/core/bclru_pkg.sv
// ============================================================================
// bclru_pkg
// Shared sizes, outcome codes and the result type of the block cache LRU
// tag manager.
// ============================================================================
`default_nettype none

package bclru_pkg;

    // Address and block geometry.
    localparam int ADDR_W        = 40;
    localparam int ADDR_BITS     = 40;
    localparam int BLOCK_BYTES   = 4096;
    localparam int OFFS_BITS     = $clog2(BLOCK_BYTES);
    localparam int TAG_BITS      = ADDR_BITS - OFFS_BITS;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam int RANK_BITS     = SLOT_BITS;
    localparam int COUNT_BITS    = $clog2(TABLE_ENTRIES + 1);

    // Stream payload widths.
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 96;
    localparam int OUT_USER_W    = 3;

    typedef enum logic [1:0] {
        OUT_NEWEST = 2'd0,
        OUT_SECOND = 2'd1,
        OUT_TABLE  = 2'd2,
        OUT_MISS   = 2'd3
    } t_outcome;

    typedef struct packed {
        t_outcome              outcome;
        logic [SLOT_BITS-1:0]  slot;
        logic [ADDR_W-1:0]     block_base;
        logic [OFFS_BITS-1:0]  offset;
        logic                  evicted;
        logic [ADDR_W-1:0]     evicted_base;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/bclru_tag_table.sv
// ============================================================================
// bclru_tag_table
// Tag store, valid bits, recency ranks and the two recent-slot pointers,
// with the combinational lookup and registered update for one address.
// ============================================================================
`default_nettype none

module bclru_tag_table
    import bclru_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [ADDR_W-1:0] i_addr,
    output t_result                o_result
);

    logic [TAG_BITS-1:0]   r_tag [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [RANK_BITS-1:0]  r_rank [TABLE_ENTRIES];
    logic [RANK_BITS-1:0]  n_rank [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [SLOT_BITS-1:0]  r_newest, n_newest, r_second, n_second;
    logic                  r_newest_valid, n_newest_valid;
    logic                  r_second_valid, n_second_valid;

    logic [TAG_BITS-1:0]      w_tag;
    logic [TABLE_ENTRIES-1:0] w_match;
    logic [TABLE_ENTRIES-1:0] w_worst_oh;
    logic [SLOT_BITS-1:0]     w_hit_slot, w_free_slot, w_worst_slot, w_slot;
    logic [TAG_BITS-1:0]      w_worst_tag;
    logic                     w_hit_new, w_hit_sec, w_full, w_tag_we, w_cur_newest_valid;
    logic [TABLE_ENTRIES-1:0] w_valid_left;
    logic [RANK_BITS-1:0]     w_old_rank;

    assign w_tag = i_addr[ADDR_BITS-1:OFFS_BITS];

    // Parallel compares, pointer checks, and priority encoders.
    always_comb begin
        w_hit_slot   = '0;
        w_free_slot  = '0;
        w_worst_slot = '0;
        w_worst_tag  = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == w_tag);
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_slot = SLOT_BITS'(i);
            end
            if (!r_valid[i]) begin
                w_free_slot = SLOT_BITS'(i);
            end
        end
        // The least recent entry is the lowest slot holding the highest rank.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_worst_oh[i] = r_valid[i];
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                if (j < i && r_valid[j] && r_rank[j] >= r_rank[i]) begin
                    w_worst_oh[i] = 1'b0;
                end
                if (j > i && r_valid[j] && r_rank[j] > r_rank[i]) begin
                    w_worst_oh[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_worst_oh[i]) begin
                w_worst_slot = w_worst_slot | SLOT_BITS'(i);
                w_worst_tag  = w_worst_tag | r_tag[i];
            end
        end
        w_hit_new = r_newest_valid && w_match[r_newest];
        w_hit_sec = r_second_valid && w_match[r_second];
        w_full    = (r_count == COUNT_BITS'(TABLE_ENTRIES));
    end

    // Outcome and next state.
    always_comb begin
        n_valid            = r_valid;
        n_rank             = r_rank;
        n_count            = r_count;
        n_newest           = r_newest;
        n_newest_valid     = r_newest_valid;
        n_second           = r_second;
        n_second_valid     = r_second_valid;
        w_tag_we           = 1'b0;
        w_slot             = '0;
        w_valid_left       = r_valid;
        w_cur_newest_valid = r_newest_valid;
        w_old_rank         = r_rank[w_hit_slot];

        o_result.outcome      = OUT_NEWEST;
        o_result.evicted      = 1'b0;
        o_result.evicted_base = '0;

        priority if (w_hit_new) begin
            w_slot = r_newest;
        end else if (w_hit_sec) begin
            o_result.outcome = OUT_SECOND;
            w_slot           = r_second;
            n_newest         = r_second;
            n_newest_valid   = r_second_valid;
            n_second         = r_newest;
            n_second_valid   = r_newest_valid;
        end else begin
            if (|w_match) begin
                o_result.outcome = OUT_TABLE;
                w_slot           = w_hit_slot;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (r_valid[i] && SLOT_BITS'(i) != w_hit_slot && r_rank[i] < w_old_rank) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[w_hit_slot] = '0;
            end else begin
                o_result.outcome = OUT_MISS;
                w_tag_we         = 1'b1;
                if (w_full) begin
                    w_slot                     = w_worst_slot;
                    o_result.evicted           = 1'b1;
                    o_result.evicted_base      = {w_worst_tag, OFFS_BITS'(0)};
                    w_valid_left[w_worst_slot] = 1'b0;
                    if (r_newest == w_worst_slot) begin
                        w_cur_newest_valid = 1'b0;
                    end
                end else begin
                    w_slot  = w_free_slot;
                    n_count = r_count + 1'b1;
                end
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (w_valid_left[i]) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[w_slot]  = '0;
                n_valid         = w_valid_left;
                n_valid[w_slot] = 1'b1;
            end
            n_second       = r_newest;
            n_second_valid = w_cur_newest_valid;
            n_newest       = w_slot;
            n_newest_valid = 1'b1;
        end

        o_result.slot       = w_slot;
        o_result.block_base = {w_tag, OFFS_BITS'(0)};
        o_result.offset     = i_addr[OFFS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_count        <= '0;
            r_newest       <= '0;
            r_newest_valid <= 1'b0;
            r_second       <= '0;
            r_second_valid <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire) begin
            r_valid        <= n_valid;
            r_count        <= n_count;
            r_newest       <= n_newest;
            r_newest_valid <= n_newest_valid;
            r_second       <= n_second;
            r_second_valid <= n_second_valid;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Tags are read only behind their valid bits, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_fire && w_tag_we) begin
            r_tag[w_slot] <= w_tag;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bclru_out_buf.sv
// ============================================================================
// bclru_out_buf
// Two-word result FIFO with a read and a write pointer, so the
// lookup keeps running while the receiver stalls, until both words are held.
// ============================================================================
`default_nettype none

module bclru_out_buf
    import bclru_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    t_result     r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        w_pop;

    assign w_pop    = o_valid && i_ready;
    assign o_valid  = (r_count != 2'd0);
    assign o_room   = (r_count != 2'd2);
    assign o_result = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/block_cache_lru_tag_manager.sv
// ============================================================================
// block_cache_lru_tag_manager
// Fully associative LRU tag table with two recent-slot pointers.
// ============================================================================
// Usage:
//   The slave stream carries one byte address per word. The master stream
//   returns one result word per address: slot, block base, offset and the
//   evicted block base in tdata, the outcome code and the eviction flag in
//   tuser.
//   An accepted address waits in the input register until the result buffer
//   has room; then the lookup, the table update and the result write happen
//   together, and the result can be taken from the buffer.
//   Throughput is one address per cycle while the result buffer has room: the
//   tag compare, LRU search and rank update are combinational over all 16 entries.
//   Reset clears all valid bits, ranks, the entry count and both pointers;
//   the table is empty afterwards.
//   When the receiver stalls, a two-word result buffer absorbs results; once
//   it is full the input register holds its address and o_s_tready drops.
// ============================================================================
`default_nettype none

module block_cache_lru_tag_manager
    import bclru_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [39:0] addr
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [3:0] slot, [43:4] block_base,
                                                    // [55:44] offset, [95:56] evicted_base
    output logic [OUT_USER_W-1:0]      o_m_tuser    // [1:0] outcome, [2] evicted
);

    logic              r_in_valid;
    logic [ADDR_W-1:0] r_addr;
    logic              w_room, w_fire, w_accept;
    t_result           w_result, w_out;

    assign w_fire     = r_in_valid && w_room;
    assign o_s_tready = !r_in_valid || w_room;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= i_s_tdata[ADDR_W-1:0];
        end
    end

    bclru_tag_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_addr   (r_addr),
        .o_result (w_result)
    );

    bclru_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fire),
        .i_result (w_result),
        .o_room   (w_room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_out)
    );

    assign o_m_tdata = {w_out.evicted_base, w_out.offset, w_out.block_base, w_out.slot};
    assign o_m_tuser = {w_out.evicted, w_out.outcome};

endmodule

`default_nettype wire

// File: tb/sv/tb_block_cache_lru_tag_manager.sv
// ============================================================================
// tb_block_cache_lru_tag_manager
// Stream testbench for the LRU block tag manager. A queue of byte addresses
// feeds a clocked driver; a clocked monitor predicts every accepted address
// against its own copy of the tag table and checks each result word field
// by field.
// ============================================================================
`default_nettype none

module tb_block_cache_lru_tag_manager;

    import bclru_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int ITEM_TARGET = 1450;
    localparam int POOL_SIZE   = 20;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // [39:0] addr
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [3:0] slot, [43:4] block_base,
                                              // [55:44] offset, [95:56] evicted_base
    logic [OUT_USER_W-1:0] o_m_tuser;         // [1:0] outcome, [2] evicted

    block_cache_lru_tag_manager DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Addresses waiting to be driven and results waiting to be seen.
    logic [IN_DATA_W-1:0] access_q[$];
    t_result              lookup_q[$];

    int  cycle_count = 0;
    int  accepted    = 0;
    int  fail_count  = 0;
    bit  addr_taken  = 1'b0;

    // Shadow copy of the tag table and the two recent-slot pointers.
    logic [TAG_BITS-1:0]  tag_mem[TABLE_ENTRIES];
    bit                   held[TABLE_ENTRIES];
    int unsigned          rank_of[TABLE_ENTRIES];
    int unsigned          fill_count = 0;
    logic [SLOT_BITS-1:0] newest_ptr = '0;
    logic [SLOT_BITS-1:0] second_ptr = '0;
    bit                   newest_ok  = 1'b0;
    bit                   second_ok  = 1'b0;

    // Stimulus bookkeeping.
    logic [TAG_BITS-1:0]  tag_pool[POOL_SIZE];
    logic [TAG_BITS-1:0]  recent_tag[2];

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tag_mem[i] = '0;
            held[i]    = 1'b0;
            rank_of[i] = 0;
        end
    end

    function automatic t_result predict_lookup(input logic [IN_DATA_W-1:0] addr);
        t_result             r;
        logic [TAG_BITS-1:0] tag;
        logic [SLOT_BITS-1:0] swap_slot;
        bit                  swap_ok;
        bit                  found;
        bit                  any;
        int                  s;
        int                  worst;
        tag          = addr[ADDR_W-1:OFFS_BITS];
        r            = '0;
        r.block_base = {tag, {OFFS_BITS{1'b0}}};
        r.offset     = addr[OFFS_BITS-1:0];
        if (newest_ok && held[newest_ptr] && tag_mem[newest_ptr] == tag) begin
            r.outcome = OUT_NEWEST;
            r.slot    = newest_ptr;
        end else if (second_ok && held[second_ptr] && tag_mem[second_ptr] == tag) begin
            r.outcome  = OUT_SECOND;
            r.slot     = second_ptr;
            swap_slot  = newest_ptr;
            swap_ok    = newest_ok;
            newest_ptr = second_ptr;
            newest_ok  = second_ok;
            second_ptr = swap_slot;
            second_ok  = swap_ok;
        end else begin
            found = 1'b0;
            s     = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!found && held[i] && tag_mem[i] == tag) begin
                    found = 1'b1;
                    s     = i;
                end
            if (found) begin
                r.outcome = OUT_TABLE;
                // Entries that were more recent than the hit slot age by one.
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (held[i] && i != s && rank_of[i] < rank_of[s])
                        rank_of[i]++;
                rank_of[s] = 0;
            end else begin
                r.outcome = OUT_MISS;
                if (fill_count >= TABLE_ENTRIES) begin
                    worst = 0;
                    any   = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (held[i] && (!any || rank_of[i] > rank_of[worst])) begin
                            worst = i;
                            any   = 1'b1;
                        end
                    s = worst;
                    if (any) begin
                        r.evicted      = 1'b1;
                        r.evicted_base = {tag_mem[worst], {OFFS_BITS{1'b0}}};
                        held[worst]    = 1'b0;
                        // A pointer to the evicted slot must not hit any more.
                        if (newest_ok && newest_ptr == worst)
                            newest_ok = 1'b0;
                        if (second_ok && second_ptr == worst)
                            second_ok = 1'b0;
                    end
                    fill_count = TABLE_ENTRIES;
                end else begin
                    found = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (!found && !held[i]) begin
                            s     = i;
                            found = 1'b1;
                        end
                    fill_count++;
                end
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (held[i])
                        rank_of[i]++;
                tag_mem[s] = tag;
                held[s]    = 1'b1;
                rank_of[s] = 0;
            end
            r.slot     = s[SLOT_BITS-1:0];
            second_ptr = newest_ptr;
            second_ok  = newest_ok;
            newest_ptr = s[SLOT_BITS-1:0];
            newest_ok  = 1'b1;
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Random gaps on both sides, except for a gap-free stretch mid-run.
    function automatic bit pause_now();
        return (accepted < 500 || accepted > 850) && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic logic [OFFS_BITS-1:0] pick_offset();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        else if (k == 1)
            return '1;
        return OFFS_BITS'($urandom());
    endfunction

    function automatic logic [TAG_BITS-1:0] random_tag();
        return TAG_BITS'($urandom());
    endfunction

    task automatic push_access(input logic [TAG_BITS-1:0] tag,
                               input logic [OFFS_BITS-1:0] offs);
        access_q.push_back({tag, offs});
        if (tag != recent_tag[0]) begin
            recent_tag[1] = recent_tag[0];
            recent_tag[0] = tag;
        end
    endtask

    // Keeps one block on a pointer while its rank climbs to least recent, so
    // that a later fill evicts the block a pointer still refers to.
    task automatic pinned_block_run();
        logic [TAG_BITS-1:0] pinned;
        pinned = random_tag();
        push_access(pinned, pick_offset());
        repeat (15) begin
            push_access(random_tag(), pick_offset());
            push_access(pinned, pick_offset());
        end
        push_access(random_tag(), pick_offset());
        push_access(random_tag(), pick_offset());
        push_access(pinned, pick_offset());
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Driver: a new word is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !pause_now();
            if (!i_s_tvalid || addr_taken) begin
                if (access_q.size() > 0 && !pause_now()) begin
                    i_s_tdata  <= access_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on every accepted address, checks every result word.
    always @(posedge i_clk) begin
        t_result want;
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, lookup_q.size());
            $display("tb_block_cache_lru_tag_manager: FAIL");
            $finish;
        end else begin
            addr_taken <= i_rst_n && i_s_tvalid && o_s_tready;
            if (i_rst_n && i_s_tvalid && o_s_tready) begin
                lookup_q.push_back(predict_lookup(i_s_tdata));
                accepted++;
            end
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (lookup_q.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h/%h",
                             $time, o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    want = lookup_q.pop_front();
                    compare_field("outcome", want.outcome, o_m_tuser[1:0]);
                    compare_field("evicted", want.evicted, o_m_tuser[2]);
                    compare_field("slot", want.slot, o_m_tdata[3:0]);
                    compare_field("block_base", want.block_base, o_m_tdata[43:4]);
                    compare_field("offset", want.offset, o_m_tdata[55:44]);
                    compare_field("evicted_base", want.evicted_base, o_m_tdata[95:56]);
                end
            end
        end
    end

    initial begin
        int k;
        recent_tag[0] = '0;
        recent_tag[1] = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = random_tag();

        // Directed part: pointer hits both ways, a table hit, a full table
        // and an eviction of the least recent block.
        push_access('0, '0);
        push_access('0, '1);
        push_access('1, '1);
        push_access('0, 12'h800);
        push_access('1, '0);
        push_access(28'd1, '0);
        push_access('0, 12'h001);
        for (int i = 0; i < 14; i++)
            push_access((i == 0) ? 28'h5555555 : (i == 1) ? 28'hAAAAAAA : 28'(i + 2),
                        pick_offset());
        push_access('1, 12'h005);

        while (access_q.size() < ITEM_TARGET) begin
            k = $urandom_range(0, 99);
            if (k < 25)
                push_access(recent_tag[0], pick_offset());
            else if (k < 40)
                push_access(recent_tag[1], pick_offset());
            else if (k < 75)
                push_access(tag_pool[$urandom_range(0, POOL_SIZE - 1)], pick_offset());
            else if (k < 90)
                push_access(random_tag(), pick_offset());
            else if (k < 99) begin
                tag_pool[$urandom_range(0, POOL_SIZE - 1)] = random_tag();
                access_q.push_back(IN_DATA_W'({$urandom(), $urandom()}));
            end else
                pinned_block_run();
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (access_q.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (lookup_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && lookup_q.size() == 0)
            $display("tb_block_cache_lru_tag_manager: PASS");
        else
            $display("tb_block_cache_lru_tag_manager: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
